### design/dpb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package dpb_pkg;

    // Configuration register indexes.
    localparam logic [2:0] REG_FOCAL_X_RECIP     = 3'd0;
    localparam logic [2:0] REG_FOCAL_Y_RECIP     = 3'd1;
    localparam logic [2:0] REG_CENTER_X          = 3'd2;
    localparam logic [2:0] REG_CENTER_Y          = 3'd3;
    localparam logic [2:0] REG_DEPTH_SCALE_RECIP = 3'd4;

    // Reset values of the configuration registers.
    localparam logic [23:0] FOCAL_X_RECIP_RST     = 24'd32388;
    localparam logic [23:0] FOCAL_Y_RECIP_RST     = 24'd32326;
    localparam logic [15:0] CENTER_X_RST          = 16'd5208;
    localparam logic [15:0] CENTER_Y_RST          = 16'd4056;
    localparam logic [31:0] DEPTH_SCALE_RECIP_RST = 32'd4294967;

    localparam int unsigned PIX_FIELD_W = 12;

    typedef struct packed {
        logic [PIX_FIELD_W-1:0] column;
        logic [PIX_FIELD_W-1:0] row;
        logic [15:0]            depth_raw;
        logic [7:0]             blue_in;
        logic [7:0]             green_in;
        logic [7:0]             red_in;
    } in_word_t;

    typedef struct packed {
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic [31:0]        point_z;
        logic [7:0]         red_out;
        logic [7:0]         green_out;
        logic [7:0]         blue_out;
    } out_word_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } rgb_t;

endpackage

`default_nettype wire

### design/depth_pixel_backprojection_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake                    Word
// in        input      in_valid / in_ready          in_data   (in_word_t)
// out       output     out_valid / out_ready        out_data  (out_word_t)
// cfg       input      cfg_wr_en (no wait)          cfg_index, cfg_data
//
// Four register stages: depth scaling, offset times z, reciprocal products,
// then sum, saturation and the output register. An accepted word passes
// through stages 1 to 4 in order and out_valid is the stage 4 valid bit; one
// word is taken every cycle unless the output stalls with every stage full.
// A pixel with zero depth is accepted and dropped at the first stage.
// Reset clears the stage valid bits and loads the default camera model.
// A stall at the output holds each full stage with no empty stage after it.
module depth_pixel_backprojection_core
    import dpb_pkg::*;
#(
    parameter int COORD_BITS = 12
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire in_word_t    in_data,
    output logic             out_valid,
    input  wire logic        out_ready,
    output out_word_t        out_data,
    input  wire logic        cfg_wr_en,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [31:0] cfg_data
);

    // Only the low coordinate bits of a pixel index take part.
    localparam int USE_BITS = (COORD_BITS < PIX_FIELD_W) ? COORD_BITS : PIX_FIELD_W;
    localparam logic [PIX_FIELD_W-1:0] COORD_MASK =
        {PIX_FIELD_W{1'b1}} >> (PIX_FIELD_W - USE_BITS);

    // Configuration registers.
    logic [23:0] focal_x_recip_reg;
    logic [23:0] focal_y_recip_reg;
    logic [15:0] center_x_reg;
    logic [15:0] center_y_reg;
    logic [31:0] depth_scale_recip_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            focal_x_recip_reg     <= FOCAL_X_RECIP_RST;
            focal_y_recip_reg     <= FOCAL_Y_RECIP_RST;
            center_x_reg          <= CENTER_X_RST;
            center_y_reg          <= CENTER_Y_RST;
            depth_scale_recip_reg <= DEPTH_SCALE_RECIP_RST;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_FOCAL_X_RECIP:     focal_x_recip_reg     <= cfg_data[23:0];
                REG_FOCAL_Y_RECIP:     focal_y_recip_reg     <= cfg_data[23:0];
                REG_CENTER_X:          center_x_reg          <= cfg_data[15:0];
                REG_CENTER_Y:          center_y_reg          <= cfg_data[15:0];
                REG_DEPTH_SCALE_RECIP: depth_scale_recip_reg <= cfg_data;
                default:               ;
            endcase
        end
    end

    // Stage handshake: a stage loads when it is empty or its word moves on.
    logic s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg;
    logic en1, en2, en3, en4;

    assign en4      = !s4_valid_reg || out_ready;
    assign en3      = !s3_valid_reg || en4;
    assign en2      = !s2_valid_reg || en3;
    assign en1      = !s1_valid_reg || en2;
    assign in_ready = en1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end
        else
        begin
            if (en1)
            begin
                s1_valid_reg <= in_valid && (in_data.depth_raw != 16'd0);
            end
            if (en2)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (en3)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
            if (en4)
            begin
                s4_valid_reg <= s3_valid_reg;
            end
        end
    end

    // Stage 1: depth times scale, and the signed offsets from the centre.
    logic [47:0] s1_prod_reg, s1_prod_next;
    logic [15:0] s1_dx_reg, s1_dx_next;
    logic [15:0] s1_dy_reg, s1_dy_next;
    logic        s1_negx_reg, s1_negx_next;
    logic        s1_negy_reg, s1_negy_next;
    rgb_t        s1_rgb_reg, s1_rgb_next;
    logic [15:0] pix_x16;
    logic [15:0] pix_y16;

    always_comb
    begin
        pix_x16      = {in_data.column & COORD_MASK, 4'b0000};
        pix_y16      = {in_data.row & COORD_MASK, 4'b0000};
        s1_prod_next = {32'd0, in_data.depth_raw} * {16'd0, depth_scale_recip_reg};
        s1_negx_next = pix_x16 < center_x_reg;
        s1_negy_next = pix_y16 < center_y_reg;
        s1_dx_next   = s1_negx_next ? (center_x_reg - pix_x16) : (pix_x16 - center_x_reg);
        s1_dy_next   = s1_negy_next ? (center_y_reg - pix_y16) : (pix_y16 - center_y_reg);
        s1_rgb_next  = '{red: in_data.red_in, green: in_data.green_in,
                         blue: in_data.blue_in};
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            s1_prod_reg <= s1_prod_next;
            s1_dx_reg   <= s1_dx_next;
            s1_dy_reg   <= s1_dy_next;
            s1_negx_reg <= s1_negx_next;
            s1_negy_reg <= s1_negy_next;
            s1_rgb_reg  <= s1_rgb_next;
        end
    end

    // Stage 2: offset magnitudes times z.
    logic [31:0] s2_z_reg, s2_z_next;
    logic [47:0] s2_ax_reg, s2_ax_next;
    logic [47:0] s2_ay_reg, s2_ay_next;
    logic        s2_negx_reg, s2_negy_reg;
    rgb_t        s2_rgb_reg;

    always_comb
    begin
        s2_z_next  = s1_prod_reg[47:16];
        s2_ax_next = {32'd0, s1_dx_reg} * {16'd0, s2_z_next};
        s2_ay_next = {32'd0, s1_dy_reg} * {16'd0, s2_z_next};
    end

    always_ff @(posedge clk)
    begin
        if (en2)
        begin
            s2_z_reg    <= s2_z_next;
            s2_ax_reg   <= s2_ax_next;
            s2_ay_reg   <= s2_ay_next;
            s2_negx_reg <= s1_negx_reg;
            s2_negy_reg <= s1_negy_reg;
            s2_rgb_reg  <= s1_rgb_reg;
        end
    end

    // Stage 3: the 48-bit products times the focal reciprocals, split into
    // a high and a low partial product per axis.
    logic [39:0] s3_hix_reg, s3_hix_next;
    logic [55:0] s3_lox_reg, s3_lox_next;
    logic [39:0] s3_hiy_reg, s3_hiy_next;
    logic [55:0] s3_loy_reg, s3_loy_next;
    logic [31:0] s3_z_reg;
    logic        s3_negx_reg, s3_negy_reg;
    rgb_t        s3_rgb_reg;

    always_comb
    begin
        s3_hix_next = {24'd0, s2_ax_reg[47:32]} * {16'd0, focal_x_recip_reg};
        s3_lox_next = {24'd0, s2_ax_reg[31:0]} * {32'd0, focal_x_recip_reg};
        s3_hiy_next = {24'd0, s2_ay_reg[47:32]} * {16'd0, focal_y_recip_reg};
        s3_loy_next = {24'd0, s2_ay_reg[31:0]} * {32'd0, focal_y_recip_reg};
    end

    always_ff @(posedge clk)
    begin
        if (en3)
        begin
            s3_hix_reg  <= s3_hix_next;
            s3_lox_reg  <= s3_lox_next;
            s3_hiy_reg  <= s3_hiy_next;
            s3_loy_reg  <= s3_loy_next;
            s3_z_reg    <= s2_z_reg;
            s3_negx_reg <= s2_negx_reg;
            s3_negy_reg <= s2_negy_reg;
            s3_rgb_reg  <= s2_rgb_reg;
        end
    end

    // Stage 4: Q16.16 magnitude, truncated toward zero, then sign and
    // saturation into the output register.
    function automatic logic [31:0] sat_signed(input logic [44:0] mag, input logic neg);
        logic [31:0] res;
        if (neg)
        begin
            if (mag >= 45'h0_8000_0000)
            begin
                res = 32'h8000_0000;
            end
            else
            begin
                res = 32'd0 - mag[31:0];
            end
        end
        else if (mag > 45'h0_7FFF_FFFF)
        begin
            res = 32'h7FFF_FFFF;
        end
        else
        begin
            res = mag[31:0];
        end
        return res;
    endfunction

    logic [44:0] magx;
    logic [44:0] magy;
    out_word_t   out_reg, out_next;

    always_comb
    begin
        magx = {1'b0, s3_hix_reg, 4'b0000} + {17'd0, s3_lox_reg[55:28]};
        magy = {1'b0, s3_hiy_reg, 4'b0000} + {17'd0, s3_loy_reg[55:28]};
        out_next.point_x   = sat_signed(magx, s3_negx_reg);
        out_next.point_y   = sat_signed(magy, s3_negy_reg);
        out_next.point_z   = s3_z_reg;
        out_next.red_out   = s3_rgb_reg.red;
        out_next.green_out = s3_rgb_reg.green;
        out_next.blue_out  = s3_rgb_reg.blue;
    end

    always_ff @(posedge clk)
    begin
        if (en4)
        begin
            out_reg <= out_next;
        end
    end

    assign out_valid = s4_valid_reg;
    assign out_data  = out_reg;

endmodule

`default_nettype wire

### verif/tb_depth_pixel_backprojection_core.sv
`timescale 1ns / 1ps

module tb_depth_pixel_backprojection_core;
    import dpb_pkg::*;

    localparam int COORD_BITS   = 12;
    localparam int LONG_HOLD    = 80;
    localparam int DRAIN_CYCLES = 12;
    localparam int RUN_LIMIT_NS = 400_000;

    typedef enum int {RX_ALWAYS, RX_HALF, RX_MOSTLY, RX_RARELY} rx_mode_t;

    // Holds the camera model and works out the point each pixel should give.
    class point_predictor;
        logic [23:0] rcp_fx;
        logic [23:0] rcp_fy;
        logic [15:0] ctr_x;
        logic [15:0] ctr_y;
        logic [31:0] depth_gain;
        out_word_t   pending_points[$];
        int          mismatches;

        function new();
            rcp_fx     = FOCAL_X_RECIP_RST;
            rcp_fy     = FOCAL_Y_RECIP_RST;
            ctr_x      = CENTER_X_RST;
            ctr_y      = CENTER_Y_RST;
            depth_gain = DEPTH_SCALE_RECIP_RST;
            mismatches = 0;
        endfunction

        function void write_reg(logic [2:0] idx, logic [31:0] data);
            case (idx)
                REG_FOCAL_X_RECIP:     rcp_fx = data[23:0];
                REG_FOCAL_Y_RECIP:     rcp_fy = data[23:0];
                REG_CENTER_X:          ctr_x = data[15:0];
                REG_CENTER_Y:          ctr_y = data[15:0];
                REG_DEPTH_SCALE_RECIP: depth_gain = data;
                default: ;
            endcase
        endfunction

        // Offset from the principal point times z times the reciprocal focal
        // length. The magnitude is truncated, so the result rounds toward zero.
        function logic [31:0] project(logic [PIX_FIELD_W-1:0] pix, logic [15:0] ctr,
                                      logic [31:0] z, logic [23:0] rcp);
            logic [63:0] p16;
            logic [63:0] offset;
            logic [63:0] prod;
            logic [63:0] mag;
            logic        below;
            p16    = (64'(pix) & ((64'd1 << COORD_BITS) - 64'd1)) << 4;
            below  = p16 < 64'(ctr);
            offset = below ? (64'(ctr) - p16) : (p16 - 64'(ctr));
            prod   = offset * 64'(z);
            mag    = (((prod >> 32) * 64'(rcp)) << 4) +
                     ((64'(prod[31:0]) * 64'(rcp)) >> 28);
            if (below)
                return (mag >= 64'h8000_0000) ? 32'h8000_0000 : 32'(64'd0 - mag);
            return (mag > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : mag[31:0];
        endfunction

        function void note_pixel(in_word_t px);
            out_word_t   pt;
            logic [47:0] scaled;
            if (px.depth_raw == 16'd0)
                return;
            scaled       = 48'(px.depth_raw) * 48'(depth_gain);
            pt.point_z   = scaled[47:16];
            pt.point_x   = project(px.column, ctr_x, pt.point_z, rcp_fx);
            pt.point_y   = project(px.row, ctr_y, pt.point_z, rcp_fy);
            pt.red_out   = px.red_in;
            pt.green_out = px.green_in;
            pt.blue_out  = px.blue_in;
            pending_points.insert(pending_points.size(), pt);
        endfunction

        function void check_point(out_word_t got);
            out_word_t want;
            if (pending_points.size() == 0)
            begin
                $error("point with no pixel pending: x=%0d y=%0d z=%0d",
                       got.point_x, got.point_y, got.point_z);
                mismatches++;
                return;
            end
            want = pending_points.pop_front();
            if (got.point_x !== want.point_x)
            begin
                $error("point_x: expected %0d, got %0d", want.point_x, got.point_x);
                mismatches++;
            end
            if (got.point_y !== want.point_y)
            begin
                $error("point_y: expected %0d, got %0d", want.point_y, got.point_y);
                mismatches++;
            end
            if (got.point_z !== want.point_z)
            begin
                $error("point_z: expected %0d, got %0d", want.point_z, got.point_z);
                mismatches++;
            end
            if (got.red_out !== want.red_out)
            begin
                $error("red_out: expected %0d, got %0d", want.red_out, got.red_out);
                mismatches++;
            end
            if (got.green_out !== want.green_out)
            begin
                $error("green_out: expected %0d, got %0d", want.green_out, got.green_out);
                mismatches++;
            end
            if (got.blue_out !== want.blue_out)
            begin
                $error("blue_out: expected %0d, got %0d", want.blue_out, got.blue_out);
                mismatches++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    in_word_t    in_data;
    logic        out_valid;
    logic        out_ready;
    out_word_t   out_data;
    logic        cfg_wr_en;
    logic [2:0]  cfg_index;
    logic [31:0] cfg_data;

    point_predictor projector;
    int             holds_asked  = 0;
    int             holds_served = 0;
    int             burst_left   = 0;

    depth_pixel_backprojection_core #(
        .COORD_BITS (COORD_BITS)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial clk = 1'b0;
    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        if (in_valid && in_ready)
            projector.note_pixel(in_data);
        if (out_valid && out_ready)
            projector.check_point(out_data);
        if (cfg_wr_en)
            projector.write_reg(cfg_index, cfg_data);
    end

    // The receiver switches between stall patterns, and now and then holds off
    // for a long stretch so that the pipeline fills and pushes back.
    initial
    begin
        rx_mode_t mode;
        int       run;
        out_ready = 1'b0;
        mode = RX_ALWAYS;
        run = 0;
        forever
        begin
            @(negedge clk);
            if (holds_served != holds_asked)
            begin
                holds_served++;
                out_ready <= 1'b0;
                repeat (LONG_HOLD) @(negedge clk);
            end
            else
            begin
                if (run == 0)
                begin
                    mode = rx_mode_t'($urandom_range(0, 3));
                    run = $urandom_range(5, 60);
                end
                run--;
                case (mode)
                    RX_ALWAYS: out_ready <= 1'b1;
                    RX_HALF:   out_ready <= 1'($urandom_range(0, 1));
                    RX_MOSTLY: out_ready <= ($urandom_range(0, 9) != 0);
                    RX_RARELY: out_ready <= ($urandom_range(0, 3) == 0);
                    default:   out_ready <= 1'b1;
                endcase
            end
        end
    end

    task automatic send_pixel(input in_word_t px);
        @(negedge clk);
        in_valid <= 1'b1;
        in_data  <= px;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    // Unused high bits of the narrower registers carry noise.
    task automatic set_camera(input logic [23:0] fx, input logic [23:0] fy,
                              input logic [15:0] cx, input logic [15:0] cy,
                              input logic [31:0] gain);
        write_reg(REG_FOCAL_X_RECIP, {8'($urandom), fx});
        write_reg(REG_FOCAL_Y_RECIP, {8'($urandom), fy});
        write_reg(REG_CENTER_X, {16'($urandom), cx});
        write_reg(REG_CENTER_Y, {16'($urandom), cy});
        write_reg(REG_DEPTH_SCALE_RECIP, gain);
    endtask

    // Pixels with zero depth produce nothing, so the pipeline may still hold
    // a word when the last point arrives; give it time to empty.
    task automatic settle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (projector.pending_points.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    function automatic in_word_t make_pixel(int col, int row, int depth,
                                            int b, int g, int r);
        in_word_t px;
        px.column    = PIX_FIELD_W'(col);
        px.row       = PIX_FIELD_W'(row);
        px.depth_raw = 16'(depth);
        px.blue_in   = 8'(b);
        px.green_in  = 8'(g);
        px.red_in    = 8'(r);
        return px;
    endfunction

    function automatic in_word_t rand_pixel();
        in_word_t px;
        int       pick;
        px = in_word_t'({$urandom, $urandom});
        pick = $urandom_range(0, 9);
        if (pick == 0)
            px.depth_raw = 16'd0;
        else if (pick <= 2)
            px.depth_raw = 16'($urandom_range(1, 255));
        else if (pick == 3)
            px.depth_raw = 16'hFFFF;
        return px;
    endfunction

    task automatic run_pixels(input int count, input bit squeeze);
        int gap;
        for (int i = 0; i < count; i++)
        begin
            if (burst_left == 0)
            begin
                gap = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 20)
                                                  : $urandom_range(1, 4);
                repeat (gap)
                begin
                    @(negedge clk);
                    in_valid <= 1'b0;
                end
                burst_left = $urandom_range(1, 40);
            end
            burst_left--;
            if (squeeze && i == count / 3)
            begin
                holds_asked++;
                burst_left = 60;
            end
            send_pixel(rand_pixel());
        end
    endtask

    initial
    begin
        projector = new();
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_data   = '0;
        cfg_wr_en = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Default camera model: corners, near the principal point, zero depth.
        send_pixel(make_pixel(0, 0, 65535, 8'h00, 8'h00, 8'h00));
        send_pixel(make_pixel(4095, 4095, 65535, 8'hFF, 8'hFF, 8'hFF));
        send_pixel(make_pixel(0, 4095, 1, 8'h12, 8'h34, 8'h56));
        send_pixel(make_pixel(4095, 0, 1, 8'hA5, 8'h5A, 8'hC3));
        send_pixel(make_pixel(325, 253, 1000, 8'h01, 8'h80, 8'hFE));
        send_pixel(make_pixel(100, 200, 0, 8'h11, 8'h22, 8'h33));
        send_pixel(make_pixel(4095, 4095, 0, 8'hFF, 8'hFF, 8'hFF));
        send_pixel(make_pixel(2048, 2048, 32768, 8'hAA, 8'h55, 8'hAA));
        send_pixel(make_pixel(1, 1, 65535, 8'h7F, 8'h00, 8'h80));
        run_pixels(150, 1'b1);
        settle();

        // Largest reciprocals and gain: x saturates high, y saturates low.
        set_camera(24'hFF_FFFF, 24'hFF_FFFF, 16'h0000, 16'hFFFF, 32'hFFFF_FFFF);
        send_pixel(make_pixel(4095, 0, 65535, 8'h0F, 8'hF0, 8'h3C));
        send_pixel(make_pixel(0, 4095, 65535, 8'hC3, 8'h3C, 8'h0F));
        send_pixel(make_pixel(4095, 4095, 1, 8'h00, 8'hFF, 8'h00));
        send_pixel(make_pixel(0, 0, 0, 8'hFF, 8'h00, 8'hFF));
        run_pixels(150, 1'b0);
        settle();

        // Writes to indexes beyond the last register must change nothing.
        for (int k = REG_DEPTH_SCALE_RECIP + 1; k < 8; k++)
            write_reg(3'(k), $urandom);
        set_camera(24'h00_0000, 24'h00_0001, 16'hFFFF, 16'h0000, 32'h0000_0001);
        run_pixels(100, 1'b0);
        settle();

        // A plausible camera with focal lengths of 200 to 2000 pixels.
        set_camera(24'((32'd1 << 24) / $urandom_range(200, 2000)),
                   24'((32'd1 << 24) / $urandom_range(200, 2000)),
                   16'($urandom), 16'($urandom),
                   32'($urandom_range(32'h0010_0000, 32'h0400_0000)));
        run_pixels(225, 1'b1);
        settle();

        set_camera(24'($urandom), 24'($urandom), 16'($urandom), 16'($urandom), $urandom);
        run_pixels(225, 1'b0);
        settle();

        if (projector.mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        #(RUN_LIMIT_NS);
        $display("== FAIL ==");
        $finish;
    end

endmodule
